/* rtl/core/cgt_pkg.sv */
// Package: constants, register codes and pipeline payload types of the tessellator.
`timescale 1ns / 1ps

package cgt_pkg;

   // Default build parameters
   localparam int MAX_COLS_DEFAULT      = 1024;
   localparam int MAX_ROWS_DEFAULT      = 1024;
   localparam int CORDIC_STAGES_DEFAULT = 16;

   // Field widths
   localparam int COUNT_W = 11;
   localparam int POS_W   = 31;
   localparam int ROLL_W  = 32;
   localparam int ANGLE_W = 25;
   localparam int VTX_W   = 21;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   // CORDIC datapath widths
   localparam int CX_W = 41;   // x, y: radius * gain with 8 guard bits plus growth
   localparam int CZ_W = 24;   // residual angle, turns * 2^24

   // CORDIC gain * 2^30; times the radius and >> 22 it gives 8 extra fraction bits
   localparam logic [29:0] GAIN_Q = 30'd652032874;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // atan(2^-k) in turns * 2^24
   localparam logic signed [CZ_W-1:0] ATAN_TURNS [24] = '{
      24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050,
      24'sd166669,  24'sd83416,   24'sd41718,  24'sd20860,
      24'sd10430,   24'sd5215,    24'sd2608,   24'sd1304,
      24'sd652,     24'sd326,     24'sd163,    24'sd81,
      24'sd41,      24'sd20,      24'sd10,     24'sd5,
      24'sd3,       24'sd1,       24'sd1,      24'sd0
   };

   // Register map
   typedef enum logic [2:0] {
      REG_COLUMN_COUNT = 3'd0,
      REG_ROW_COUNT    = 3'd1,
      REG_CYL_RADIUS   = 3'd2,
      REG_ANGLE_STEP   = 3'd3,
      REG_ARC_STEP     = 3'd4,
      REG_ROW_STEP     = 3'd5
   } reg_index_type;

   // Reset values
   localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 11'd1;
   localparam logic [COUNT_W-1:0] ROW_COUNT_RESET    = 11'd1;
   localparam logic [POS_W-1:0]   CYL_RADIUS_RESET   = 31'd65536;
   localparam logic [ANGLE_W-1:0] ANGLE_STEP_RESET   = 25'd16777216;
   localparam logic [POS_W-1:0]   ARC_STEP_RESET     = 31'd411775;
   localparam logic [POS_W-1:0]   ROW_STEP_RESET     = 31'd65536;

   // Fields carried alongside the CORDIC stages
   typedef struct packed {
      logic [POS_W-1:0] flat_x;
      logic [POS_W-1:0] flat_y;
      logic [VTX_W-1:0] vertex_index;
      logic             faces_valid;
      logic [VTX_W-1:0] tri0_corner_a;
      logic [VTX_W-1:0] tri0_corner_b;
      logic [VTX_W-1:0] tri0_corner_c;
      logic [VTX_W-1:0] tri1_corner_a;
      logic [VTX_W-1:0] tri1_corner_b;
      logic [VTX_W-1:0] tri1_corner_c;
      logic [1:0]       quadrant;
   } side_type;

   // Rotator state
   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

endpackage

/* rtl/core/cylinder_grid_tessellator_unit.sv */
// Top level: cylinder grid tessellator, pipelined CORDIC rotator and index generator.
`timescale 1ns / 1ps

// Cylinder grid tessellator.
// Request channel (req_valid / req_stall) carries one grid point, row and
// column; points beyond the configured counts are clamped to the grid edge.
// Result channel (rsp_valid / rsp_stall) returns, for each point, the flat
// sheet position, the position rolled onto the cylinder, the vertex index and,
// when row and column are both nonzero, the two triangles of the quad whose
// upper-right corner is the point.
// Registers sit on the APB-style csr_ port at byte address 4*index; the user
// must write them only while no transfer is in flight, the block does not enforce it.
// Stages: clamp, multiply, index/angle prep, one per CORDIC rotation step, then
// quadrant fold and rounding. Throughput: one point per cycle while rsp_stall is
// low; the rotator stages set the depth, each holds one point.
// Each stage moves whenever it is empty or the stage after it moves, so a
// stalled result holds its stage while bubbles upstream still fill; once the
// whole pipe is full, req_stall rises. Nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipe and loads the register
// reset values.
module cylinder_grid_tessellator_unit #(
   parameter int MAX_COLS      = cgt_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS      = cgt_pkg::MAX_ROWS_DEFAULT,
   parameter int CORDIC_STAGES = cgt_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cgt_pkg::COUNT_W-1:0]   req_grid_row,
   input  logic [cgt_pkg::COUNT_W-1:0]   req_grid_col,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cgt_pkg::POS_W-1:0]     rsp_flat_x,
   output logic [cgt_pkg::POS_W-1:0]     rsp_flat_y,
   output logic signed [cgt_pkg::ROLL_W-1:0] rsp_rolled_x,
   output logic signed [cgt_pkg::ROLL_W-1:0] rsp_rolled_y,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_vertex_index,
   output logic                          rsp_faces_valid,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_tri0_corner_a,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_tri0_corner_b,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_tri0_corner_c,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_tri1_corner_a,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_tri1_corner_b,
   output logic [cgt_pkg::VTX_W-1:0]     rsp_tri1_corner_c,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cgt_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [cgt_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [cgt_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import cgt_pkg::*;

   // clamp, multiply, prep, rotator stages, output
   localparam int NS      = CORDIC_STAGES + 4;
   localparam int ST_CLMP = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_PREP = 2;
   localparam int ST_ROT  = 3;
   localparam int ST_OUT  = NS - 1;

   // ---------------------------------------------------------------- registers
   logic [COUNT_W-1:0] column_count_ff;
   logic [COUNT_W-1:0] row_count_ff;
   logic [POS_W-1:0]   cyl_radius_ff;
   logic [ANGLE_W-1:0] angle_step_ff;
   logic [POS_W-1:0]   arc_step_ff;
   logic [POS_W-1:0]   row_step_ff;

   logic               csr_write;
   reg_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         row_count_ff    <= ROW_COUNT_RESET;
         cyl_radius_ff   <= CYL_RADIUS_RESET;
         angle_step_ff   <= ANGLE_STEP_RESET;
         arc_step_ff     <= ARC_STEP_RESET;
         row_step_ff     <= ROW_STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COLUMN_COUNT: column_count_ff <= csr_pwdata[COUNT_W-1:0];
            REG_ROW_COUNT:    row_count_ff    <= csr_pwdata[COUNT_W-1:0];
            REG_CYL_RADIUS:   cyl_radius_ff   <= csr_pwdata[POS_W-1:0];
            REG_ANGLE_STEP:   angle_step_ff   <= csr_pwdata[ANGLE_W-1:0];
            REG_ARC_STEP:     arc_step_ff     <= csr_pwdata[POS_W-1:0];
            REG_ROW_STEP:     row_step_ff     <= csr_pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COLUMN_COUNT: csr_prdata = DATA_W'(column_count_ff);
         REG_ROW_COUNT:    csr_prdata = DATA_W'(row_count_ff);
         REG_CYL_RADIUS:   csr_prdata = DATA_W'(cyl_radius_ff);
         REG_ANGLE_STEP:   csr_prdata = DATA_W'(angle_step_ff);
         REG_ARC_STEP:     csr_prdata = DATA_W'(arc_step_ff);
         REG_ROW_STEP:     csr_prdata = DATA_W'(row_step_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ flow control
   // A stage loads when it is empty or its successor loads.
   logic [NS-1:0] valid_ff;
   logic [NS:0]   ready;

   always_comb begin
      ready[NS] = !rsp_stall;
      for (int s = NS - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // ------------------------------------------------------- stage 0: clamp
   logic [COUNT_W-1:0] eff_w;
   logic [COUNT_W-1:0] eff_h;
   logic [COUNT_W-1:0] s0_row_ff;
   logic [COUNT_W-1:0] s0_col_ff;
   logic [COUNT_W-1:0] s0_w_ff;
   logic [COUNT_W:0]   s0_stride_ff;

   always_comb begin
      // zero acts as one; above the build limit acts as the limit
      if (column_count_ff == '0) begin
         eff_w = COUNT_W'(1);
      end else if ({2'b00, column_count_ff} > 13'(MAX_COLS)) begin
         eff_w = COUNT_W'(MAX_COLS);
      end else begin
         eff_w = column_count_ff;
      end
      if (row_count_ff == '0) begin
         eff_h = COUNT_W'(1);
      end else if ({2'b00, row_count_ff} > 13'(MAX_ROWS)) begin
         eff_h = COUNT_W'(MAX_ROWS);
      end else begin
         eff_h = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[ST_CLMP]) begin
         s0_row_ff    <= (req_grid_row > eff_h) ? eff_h : req_grid_row;
         s0_col_ff    <= (req_grid_col > eff_w) ? eff_w : req_grid_col;
         s0_w_ff      <= eff_w;
         s0_stride_ff <= {1'b0, eff_w} + (COUNT_W+1)'(1);
      end
   end

   // ---------------------------------------------------- stage 1: multiply
   logic [2*COUNT_W+1:0]  prod_ci;
   logic [35:0]           prod_ang;
   logic [41:0]           s1_fx_ff;
   logic [41:0]           s1_fy_ff;
   logic [CZ_W-1:0]       s1_ang_ff;
   logic [VTX_W-1:0]      s1_ci_ff;
   logic [60:0]           s1_rad_ff;
   logic [COUNT_W-1:0]    s1_col_ff;
   logic [COUNT_W:0]      s1_stride_ff;
   logic                  s1_faces_ff;
   logic                  s1_odd_ff;

   assign prod_ci  = (2*COUNT_W+2)'(s0_row_ff) * (2*COUNT_W+2)'(s0_stride_ff);
   assign prod_ang = 36'(s0_col_ff) * 36'(angle_step_ff);

   always_ff @(posedge clock) begin
      if (ready[ST_MUL]) begin
         s1_fx_ff     <= 42'(s0_col_ff) * 42'(arc_step_ff);
         s1_fy_ff     <= 42'(s0_row_ff) * 42'(row_step_ff);
         s1_ang_ff    <= prod_ang[CZ_W-1:0];      // whole turns wrap
         s1_ci_ff     <= prod_ci[VTX_W-1:0];
         s1_rad_ff    <= 61'(cyl_radius_ff) * 61'(GAIN_Q);
         s1_col_ff    <= s0_col_ff;
         s1_stride_ff <= s0_stride_ff;
         s1_faces_ff  <= (s0_row_ff != '0) && (s0_col_ff != '0);
         // parity of (i-1)*W + (j-1)
         s1_odd_ff    <= (~s0_row_ff[0] & s0_w_ff[0]) ^ ~s0_col_ff[0];
      end
   end

   // ---------------------------------------- stage 2: indices, angle split
   side_type           side_ff [CORDIC_STAGES+1];
   cordic_type         rot_ff  [CORDIC_STAGES+1];
   side_type           prep_side;
   cordic_type         prep_rot;
   logic [VTX_W-1:0]   corner_a;
   logic [VTX_W-1:0]   corner_b;
   logic [VTX_W-1:0]   corner_c;
   logic [VTX_W-1:0]   corner_d;
   logic [CZ_W:0]      ang_sum;

   always_comb begin
      corner_c = s1_ci_ff + VTX_W'(s1_col_ff);
      corner_d = corner_c - VTX_W'(1);
      corner_a = corner_c - VTX_W'(s1_stride_ff) - VTX_W'(1);
      corner_b = corner_a + VTX_W'(1);

      // nearest quarter turn and residual in [-1/8, 1/8) turn
      ang_sum  = {1'b0, s1_ang_ff} + (CZ_W+1)'(24'h200000);

      prep_side.flat_x       = (s1_fx_ff > 42'(POS_MAX)) ? POS_MAX : s1_fx_ff[POS_W-1:0];
      prep_side.flat_y       = (s1_fy_ff > 42'(POS_MAX)) ? POS_MAX : s1_fy_ff[POS_W-1:0];
      prep_side.vertex_index = corner_c;
      prep_side.faces_valid  = s1_faces_ff;
      prep_side.quadrant     = ang_sum[23:22];
      if (s1_faces_ff) begin
         prep_side.tri0_corner_a = corner_a;
         prep_side.tri0_corner_b = corner_b;
         prep_side.tri0_corner_c = s1_odd_ff ? corner_d : corner_c;
         prep_side.tri1_corner_a = s1_odd_ff ? corner_b : corner_a;
         prep_side.tri1_corner_b = corner_c;
         prep_side.tri1_corner_c = corner_d;
      end else begin
         prep_side.tri0_corner_a = '0;
         prep_side.tri0_corner_b = '0;
         prep_side.tri0_corner_c = '0;
         prep_side.tri1_corner_a = '0;
         prep_side.tri1_corner_b = '0;
         prep_side.tri1_corner_c = '0;
      end

      prep_rot.x = $signed({2'b00, s1_rad_ff[60:22]});
      prep_rot.y = '0;
      prep_rot.z = $signed({2'b00, ang_sum[21:0]}) - 24'sd2097152;
   end

   always_ff @(posedge clock) begin
      if (ready[ST_PREP]) begin
         side_ff[0] <= prep_side;
         rot_ff[0]  <= prep_rot;
      end
   end

   // ------------------------------------------- rotation stages, one each
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;

      assign dx = rot_ff[k].y >>> k;   // floor shift
      assign dy = rot_ff[k].x >>> k;

      always_ff @(posedge clock) begin
         if (ready[ST_ROT+k]) begin
            side_ff[k+1] <= side_ff[k];
            if (!rot_ff[k].z[CZ_W-1]) begin
               rot_ff[k+1].x <= rot_ff[k].x - dx;
               rot_ff[k+1].y <= rot_ff[k].y + dy;
               rot_ff[k+1].z <= rot_ff[k].z - ATAN_TURNS[k];
            end else begin
               rot_ff[k+1].x <= rot_ff[k].x + dx;
               rot_ff[k+1].y <= rot_ff[k].y - dy;
               rot_ff[k+1].z <= rot_ff[k].z + ATAN_TURNS[k];
            end
         end
      end
   end

   // ------------------------------------ output: quadrant fold and round
   function automatic logic [ROLL_W-1:0] round_sat(input logic signed [CX_W:0] v);
      logic signed [CX_W:0] rounded;
      rounded = (v + (CX_W+1)'(128)) >>> 8;
      if (rounded > $signed((CX_W+1)'(32'h7FFFFFFF))) begin
         round_sat = 32'h7FFFFFFF;
      end else if (rounded < -$signed((CX_W+1)'(33'h080000000))) begin
         round_sat = 32'h80000000;
      end else begin
         round_sat = rounded[ROLL_W-1:0];
      end
   endfunction

   logic signed [CX_W:0] cos_w;
   logic signed [CX_W:0] sin_w;
   logic signed [CX_W:0] fold_x;
   logic signed [CX_W:0] fold_y;
   side_type             last_side;

   assign last_side = side_ff[CORDIC_STAGES];
   assign cos_w     = {rot_ff[CORDIC_STAGES].x[CX_W-1], rot_ff[CORDIC_STAGES].x};
   assign sin_w     = {rot_ff[CORDIC_STAGES].y[CX_W-1], rot_ff[CORDIC_STAGES].y};

   always_comb begin
      case (last_side.quadrant)
         2'd0: begin
            fold_x = cos_w;
            fold_y = sin_w;
         end
         2'd1: begin
            fold_x = -sin_w;
            fold_y = cos_w;
         end
         2'd2: begin
            fold_x = -cos_w;
            fold_y = -sin_w;
         end
         default: begin
            fold_x = sin_w;
            fold_y = -cos_w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[ST_OUT]) begin
         rsp_flat_x        <= last_side.flat_x;
         rsp_flat_y        <= last_side.flat_y;
         rsp_rolled_x      <= round_sat(fold_x);
         rsp_rolled_y      <= round_sat(fold_y);
         rsp_vertex_index  <= last_side.vertex_index;
         rsp_faces_valid   <= last_side.faces_valid;
         rsp_tri0_corner_a <= last_side.tri0_corner_a;
         rsp_tri0_corner_b <= last_side.tri0_corner_b;
         rsp_tri0_corner_c <= last_side.tri0_corner_c;
         rsp_tri1_corner_a <= last_side.tri1_corner_a;
         rsp_tri1_corner_b <= last_side.tri1_corner_b;
         rsp_tri1_corner_c <= last_side.tri1_corner_c;
      end
   end

endmodule

/* bench/tessellation_checker.sv */
// Checker: watches the tessellator channels, predicts every result and compares it.
`timescale 1ns / 1ps

module tessellation_checker #(
   parameter int MAX_COLS      = cgt_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS      = cgt_pkg::MAX_ROWS_DEFAULT,
   parameter int CORDIC_STAGES = cgt_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [cgt_pkg::COUNT_W-1:0]       req_grid_row,
   input  logic [cgt_pkg::COUNT_W-1:0]       req_grid_col,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [cgt_pkg::POS_W-1:0]         rsp_flat_x,
   input  logic [cgt_pkg::POS_W-1:0]         rsp_flat_y,
   input  logic signed [cgt_pkg::ROLL_W-1:0] rsp_rolled_x,
   input  logic signed [cgt_pkg::ROLL_W-1:0] rsp_rolled_y,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_vertex_index,
   input  logic                              rsp_faces_valid,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_tri0_corner_a,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_tri0_corner_b,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_tri0_corner_c,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_tri1_corner_a,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_tri1_corner_b,
   input  logic [cgt_pkg::VTX_W-1:0]         rsp_tri1_corner_c,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cgt_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [cgt_pkg::DATA_W-1:0]        csr_pwdata,
   input  logic                              csr_pready,
   output int                                mismatch_count,
   output int                                checked_count,
   output int                                outstanding
);
   import cgt_pkg::*;

   // radius * 0.6072529350 with 8 guard bits, after the >> 22
   localparam longint unsigned ROTATOR_GAIN = 64'd652032874;
   localparam longint unsigned FLAT_LIMIT   = 64'h0000_0000_7FFF_FFFF;
   localparam longint          ROLL_HI      = 64'sh0000_0000_7FFF_FFFF;
   localparam longint          ROLL_LO      = -64'sh0000_0000_8000_0000;

   // atan(2^-k) in turns * 2^24
   localparam longint ARCTAN_TURNS [24] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   typedef struct packed {
      logic [POS_W-1:0]  flat_x;
      logic [POS_W-1:0]  flat_y;
      logic [ROLL_W-1:0] rolled_x;
      logic [ROLL_W-1:0] rolled_y;
      logic [VTX_W-1:0]  vertex_index;
      logic              faces_valid;
      logic [VTX_W-1:0]  tri0_a;
      logic [VTX_W-1:0]  tri0_b;
      logic [VTX_W-1:0]  tri0_c;
      logic [VTX_W-1:0]  tri1_a;
      logic [VTX_W-1:0]  tri1_b;
      logic [VTX_W-1:0]  tri1_c;
   } mesh_point_type;

   // shadow copy of the register file, updated from observed csr writes
   logic [COUNT_W-1:0] cols_reg;
   logic [COUNT_W-1:0] rows_reg;
   logic [POS_W-1:0]   radius_reg;
   logic [ANGLE_W-1:0] angle_reg;
   logic [POS_W-1:0]   arc_reg;
   logic [POS_W-1:0]   rise_reg;

   mesh_point_type predicted_points[$];
   int             in_count;
   int             out_count;

   assign outstanding   = in_count - out_count;
   assign checked_count = out_count;

   function automatic longint unsigned grid_extent(input longint unsigned count,
                                                   input longint unsigned limit);
      if (count == 0) return 1;
      return (count > limit) ? limit : count;
   endfunction

   function automatic longint unsigned clip_flat(input longint unsigned v);
      return (v > FLAT_LIMIT) ? FLAT_LIMIT : v;
   endfunction

   function automatic logic [ROLL_W-1:0] clip_roll(input longint v);
      if (v > ROLL_HI) v = ROLL_HI;
      if (v < ROLL_LO) v = ROLL_LO;
      return v[ROLL_W-1:0];
   endfunction

   function automatic mesh_point_type tessellate(input logic [COUNT_W-1:0] row_in,
                                                 input logic [COUNT_W-1:0] col_in);
      mesh_point_type  p;
      longint unsigned w, h, i, j, stride, angle, qturn, rad, a, c, quad;
      longint unsigned arc, rise, turn_step;
      longint          x, y, z, dx, dy, cx, sy;
      int              k;
      w = grid_extent(64'(cols_reg), 64'(MAX_COLS));
      h = grid_extent(64'(rows_reg), 64'(MAX_ROWS));
      i = 64'(row_in);
      j = 64'(col_in);
      arc       = 64'(arc_reg);
      rise      = 64'(rise_reg);
      turn_step = 64'(angle_reg);
      rad       = 64'(radius_reg);
      if (i > h) i = h;
      if (j > w) j = w;
      stride = w + 1;
      p = '0;
      p.flat_x = POS_W'(clip_flat(j * arc));
      p.flat_y = POS_W'(clip_flat(i * rise));

      // nearest quarter turn, residual in [-2^21, 2^21)
      angle = (j * turn_step) & 64'h00FF_FFFF;
      qturn = (angle + 64'h0020_0000) >> 22;
      z = longint'(angle) - longint'(qturn << 22);
      x = longint'((rad * ROTATOR_GAIN) >> 22);
      y = 0;
      for (k = 0; k < CORDIC_STAGES && k < 24; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_TURNS[k];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_TURNS[k];
         end
      end
      case (qturn[1:0])
         2'd0: begin
            cx = x;
            sy = y;
         end
         2'd1: begin
            cx = -y;
            sy = x;
         end
         2'd2: begin
            cx = -x;
            sy = -y;
         end
         default: begin
            cx = y;
            sy = -x;
         end
      endcase
      p.rolled_x = clip_roll((cx + 128) >>> 8);
      p.rolled_y = clip_roll((sy + 128) >>> 8);

      p.vertex_index = VTX_W'(i * stride + j);
      if (i != 0 && j != 0) begin
         a    = (i - 1) * stride + (j - 1);
         c    = i * stride + j;
         quad = (i - 1) * w + (j - 1);
         p.faces_valid = 1'b1;
         p.tri0_a = VTX_W'(a);
         p.tri0_b = VTX_W'(a + 1);
         p.tri0_c = quad[0] ? VTX_W'(c - 1) : VTX_W'(c);
         p.tri1_a = quad[0] ? VTX_W'(a + 1) : VTX_W'(a);
         p.tri1_b = VTX_W'(c);
         p.tri1_c = VTX_W'(c - 1);
      end
      return p;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      mesh_point_type want;
      if (reset) begin
         cols_reg   = 11'd1;
         rows_reg   = 11'd1;
         radius_reg = 31'd65536;
         angle_reg  = 25'd16777216;
         arc_reg    = 31'd411775;
         rise_reg   = 31'd65536;
         predicted_points.delete();
         mismatch_count = 0;
         in_count  <= 0;
         out_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_COLUMN_COUNT: cols_reg   = csr_pwdata[COUNT_W-1:0];
               REG_ROW_COUNT:    rows_reg   = csr_pwdata[COUNT_W-1:0];
               REG_CYL_RADIUS:   radius_reg = csr_pwdata[POS_W-1:0];
               REG_ANGLE_STEP:   angle_reg  = csr_pwdata[ANGLE_W-1:0];
               REG_ARC_STEP:     arc_reg    = csr_pwdata[POS_W-1:0];
               REG_ROW_STEP:     rise_reg   = csr_pwdata[POS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted_points.insert(predicted_points.size(),
                                    tessellate(req_grid_row, req_grid_col));
            in_count <= in_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            out_count <= out_count + 1;
            if (predicted_points.size() == 0) begin
               $error("result transfer with no prediction pending");
               mismatch_count++;
            end else begin
               want = predicted_points.pop_front();
               check_field("flat_x", 64'(want.flat_x), 64'(rsp_flat_x));
               check_field("flat_y", 64'(want.flat_y), 64'(rsp_flat_y));
               check_field("rolled_x", 64'($signed(want.rolled_x)), 64'(rsp_rolled_x));
               check_field("rolled_y", 64'($signed(want.rolled_y)), 64'(rsp_rolled_y));
               check_field("vertex_index", 64'(want.vertex_index), 64'(rsp_vertex_index));
               check_field("faces_valid", 64'(want.faces_valid), 64'(rsp_faces_valid));
               check_field("tri0_corner_a", 64'(want.tri0_a), 64'(rsp_tri0_corner_a));
               check_field("tri0_corner_b", 64'(want.tri0_b), 64'(rsp_tri0_corner_b));
               check_field("tri0_corner_c", 64'(want.tri0_c), 64'(rsp_tri0_corner_c));
               check_field("tri1_corner_a", 64'(want.tri1_a), 64'(rsp_tri1_corner_a));
               check_field("tri1_corner_b", 64'(want.tri1_b), 64'(rsp_tri1_corner_b));
               check_field("tri1_corner_c", 64'(want.tri1_c), 64'(rsp_tri1_corner_c));
            end
         end
      end
   end

endmodule

/* bench/testbench.sv */
// Testbench top: clock, reset, grid point stimulus, register programming and verdict.
`timescale 1ns / 1ps

module testbench;
   import cgt_pkg::*;

   localparam int MAX_COLS      = MAX_COLS_DEFAULT;
   localparam int MAX_ROWS      = MAX_ROWS_DEFAULT;
   localparam int CORDIC_STAGES = CORDIC_STAGES_DEFAULT;
   localparam int PERIOD        = 10;
   // clamp, multiply, prep, the rotation stages, fold/round
   localparam int LATENCY       = CORDIC_STAGES + 4;
   // cycles without any transfer before the run is declared hung
   localparam int IDLE_LIMIT    = 2000;
   // long result hold-off, well beyond the pipe depth
   localparam int HOLD_CYCLES   = 60;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_POINTS  = 115;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   // request channel
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [COUNT_W-1:0]    req_grid_row = '0;
   logic [COUNT_W-1:0]    req_grid_col = '0;

   // result channel
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [POS_W-1:0]      rsp_flat_x;
   logic [POS_W-1:0]      rsp_flat_y;
   logic signed [ROLL_W-1:0] rsp_rolled_x;
   logic signed [ROLL_W-1:0] rsp_rolled_y;
   logic [VTX_W-1:0]      rsp_vertex_index;
   logic                  rsp_faces_valid;
   logic [VTX_W-1:0]      rsp_tri0_corner_a;
   logic [VTX_W-1:0]      rsp_tri0_corner_b;
   logic [VTX_W-1:0]      rsp_tri0_corner_c;
   logic [VTX_W-1:0]      rsp_tri1_corner_a;
   logic [VTX_W-1:0]      rsp_tri1_corner_b;
   logic [VTX_W-1:0]      rsp_tri1_corner_c;

   // configuration port
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr   = '0;
   logic [DATA_W-1:0]     csr_pwdata  = '0;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   // from the checker
   int mismatch_count;
   int checked_count;
   int outstanding;

   // stimulus control shared between the sender and the result sink
   logic quiet        = 1'b0;   // no idle cycles on either side
   logic hold_request = 1'b0;   // set by the sender, cleared by the sink after the hold
   int   points_sent   = 0;
   int   settings_used = 1;     // the reset values count as one setting
   int   idle_cycles   = 0;
   int   cols_now      = 1;     // last programmed counts, for shaping in-grid points
   int   rows_now      = 1;

   always #(PERIOD / 2) clock = ~clock;

   cylinder_grid_tessellator_unit #(
      .MAX_COLS      (MAX_COLS),
      .MAX_ROWS      (MAX_ROWS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) dut (.*);

   tessellation_checker #(
      .MAX_COLS      (MAX_COLS),
      .MAX_ROWS      (MAX_ROWS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) mesh_check (.*);

   // Effective count as the block sees it: zero acts as one, oversize clamps.
   function automatic int grid_span(input int count, input int limit);
      return (count == 0) ? 1 : ((count > limit) ? limit : count);
   endfunction

   // Mostly small grids so in-grid points hit edges and parity often; now and
   // then zero, oversize or full-size counts.
   function automatic int draw_count(input int limit);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(limit + 1, 2047);
         2:       return limit;
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   // One grid point transfer. The gap before it is drawn per item; while a
   // long hold-off is pending or the phase is quiet the sender offers
   // back-to-back so the pipe fills and req_stall rises.
   // valid stays high into the next call when that one has no gap.
   task automatic send_point(input int row, input int col);
      int gap;
      gap = (quiet || hold_request) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_grid_row <= row[COUNT_W-1:0];
      req_grid_col <= col[COUNT_W-1:0];
      do @(posedge clock); while (!(req_valid && !req_stall));
      points_sent++;
   endtask

   // Drop valid right at the last transfer and wait until every predicted
   // result has been checked. The first edge lets the checker count the
   // last transfer.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding > 0) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then an idle phase so back-to-back writes
   // never drive psel twice in one step. Bits above the register width get
   // random junk half of the time; the block keeps only the low bits.
   task automatic write_reg(input reg_index_type index, input logic [DATA_W-1:0] value,
                            input int width);
      logic [DATA_W-1:0] junk;
      logic [DATA_W-1:0] keep;
      keep = (DATA_W'(1) << width) - DATA_W'(1);
      junk = $urandom();
      if ($urandom_range(0, 1) == 0) junk = '0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= (junk & ~keep) | (value & keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Whole register set; only called with the pipe drained.
   task automatic program_grid(input int cols, input int rows, input logic [30:0] radius,
                               input logic [24:0] angle, input logic [30:0] arc,
                               input logic [30:0] rise);
      write_reg(REG_COLUMN_COUNT, DATA_W'(cols), COUNT_W);
      write_reg(REG_ROW_COUNT, DATA_W'(rows), COUNT_W);
      write_reg(REG_CYL_RADIUS, DATA_W'(radius), POS_W);
      write_reg(REG_ANGLE_STEP, DATA_W'(angle), ANGLE_W);
      write_reg(REG_ARC_STEP, DATA_W'(arc), POS_W);
      write_reg(REG_ROW_STEP, DATA_W'(rise), POS_W);
      cols_now = cols;
      rows_now = rows;
      settings_used++;
   endtask

   // Result sink: per result a stall of random length, none in quiet
   // phases. When the sender asks for it, one long hold-off follows the next
   // result transfer, counted here.
   initial begin : result_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = quiet ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Watchdog: any transfer on either channel or the csr port restarts it.
   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      int cols;
      int rows;
      int w_eff;
      logic [30:0] radius;
      logic [24:0] angle;
      logic [30:0] arc;
      logic [30:0] rise;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: 1x1 grid, full-turn step (angle always wraps to 0).
      // Origin, the one quad, both fields all ones (clamped), row zero.
      send_point(0, 0);
      send_point(1, 1);
      send_point(2047, 2047);
      send_point(0, 1);
      drain();

      // 4x3 grid, quarter-turn step: columns 1, 2 and 4 land in quadrants 1, 2 and 0.
      // Row zero / column zero give no faces; quads 0, 1, 4, 5 and 11 cover both parities;
      // the last point lies beyond the grid and clamps to the corner.
      program_grid(4, 3, 31'd655360, 25'd4194304, 31'd196608, 31'd131072);
      send_point(0, 0);
      send_point(0, 4);
      send_point(3, 0);
      send_point(1, 1);
      send_point(1, 2);
      send_point(2, 1);
      send_point(2, 2);
      send_point(3, 4);
      send_point(9, 5);
      drain();

      // Zero column count acts as one, oversize row count acts as the max;
      // every step at full scale so flat positions saturate.
      program_grid(0, 2047, 31'h7FFF_FFFF, 25'h1FF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_point(1024, 1);
      send_point(2047, 2047);
      send_point(1, 0);
      send_point(0, 1);
      drain();

      // Oversize columns, zero rows, all steps and the radius at zero.
      program_grid(2047, 0, 31'd0, 25'd0, 31'd0, 31'd0);
      send_point(1, 1024);
      send_point(1, 1023);
      send_point(0, 0);
      drain();

      // Full 1024x1024 grid; an eighth-turn step puts odd columns exactly
      // on the lower edge of the residual range.
      program_grid(1024, 1024, 31'd6553600, 25'd2097152, 31'd65536, 31'd1);
      send_point(1024, 1024);
      send_point(1023, 1023);
      send_point(512, 1);
      drain();

      // Random settings, each followed by a batch of points, mostly inside
      // the grid, some anywhere in the 11-bit field range.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         cols  = draw_count(MAX_COLS);
         rows  = draw_count(MAX_ROWS);
         w_eff = grid_span(cols, MAX_COLS);
         radius = ($urandom_range(0, 1) == 1) ? 31'($urandom() >> 1)
                                              : 31'($urandom_range(0, 32'h00FF_FFFF));
         case ($urandom_range(0, 3))
            0:       angle = 25'($urandom());
            1:       angle = 25'd2097152;
            2:       angle = 25'(32'd16777216 / w_eff);
            default: angle = 25'($urandom_range(0, 32'h0040_0000));
         endcase
         arc  = ($urandom_range(0, 1) == 1) ? 31'($urandom() >> 1)
                                            : 31'($urandom_range(0, 32'h0010_0000));
         rise = ($urandom_range(0, 1) == 1) ? 31'($urandom() >> 1)
                                            : 31'($urandom_range(0, 32'h0010_0000));
         program_grid(cols, rows, radius, angle, arc, rise);

         quiet = (phase == 2);
         // pressure phase: back-to-back requests against a held result side
         if (phase == 4) hold_request = 1'b1;

         for (n = 0; n < PHASE_POINTS; n++) begin
            if ($urandom_range(0, 99) < 85)
               send_point($urandom_range(0, grid_span(rows_now, MAX_ROWS)),
                          $urandom_range(0, grid_span(cols_now, MAX_COLS)));
            else
               send_point($urandom_range(0, 2047), $urandom_range(0, 2047));
         end
         drain();
      end
      quiet = 1'b0;

      // Anything the block still emits now shows up as an unexpected result.
      repeat (LATENCY + 4) @(posedge clock);

      $display("%0d grid points over %0d register settings, %0d results checked",
               points_sent, settings_used, checked_count);
      $display("covered zero and oversize counts, clamped points, saturation, all quadrants,");
      $display("both diagonal parities, no-idle stretches and a long result hold-off");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
